[sv/qslerp_pkg.sv]
// Package: constants, types and the arctangent table for the quaternion slerp block.
`timescale 1ns / 1ps
`default_nettype none
package qslerp_pkg;
    localparam int FRAC_BITS    = 14;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_BITS     = 30;
    localparam int SQ_STEPS     = FRAC_BITS + 1;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int EPS_RESET    = 8;

    typedef struct packed {
        logic [3:0][16:0] a;
        logic [3:0][15:0] b;
        logic [14:0]      t;
        logic [14:0]      dot;
        logic             lin;
    } t_cls;

    function automatic logic signed [32:0] atan_q30(input int i);
        logic signed [32:0] v;
        case (i)
            0:       v = 33'sd843314856;
            1:       v = 33'sd497837829;
            2:       v = 33'sd263043836;
            3:       v = 33'sd133525158;
            4:       v = 33'sd67021686;
            5:       v = 33'sd33543515;
            6:       v = 33'sd16775850;
            7:       v = 33'sd8388437;
            8:       v = 33'sd4194282;
            9:       v = 33'sd2097149;
            10:      v = 33'sd1048575;
            11:      v = 33'sd524287;
            12:      v = 33'sd262143;
            13:      v = 33'sd131071;
            14:      v = 33'sd65535;
            15:      v = 33'sd32767;
            16:      v = 33'sd16383;
            17:      v = 33'sd8191;
            18:      v = 33'sd4095;
            19:      v = 33'sd2047;
            20:      v = 33'sd1023;
            21:      v = 33'sd511;
            22:      v = 33'sd255;
            23:      v = 33'sd127;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

[sv/qslerp_if.sv]
// Interfaces: input and result channels of the quaternion slerp block.
`timescale 1ns / 1ps
`default_nettype none
interface qslerp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] first_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic signed [15:0] second_w;
    logic [14:0]        fraction;

    modport source (output valid, first_x, first_y, first_z, first_w,
                    second_x, second_y, second_z, second_w, fraction, input ready);
    modport sink (input valid, first_x, first_y, first_z, first_w,
                  second_x, second_y, second_z, second_w, fraction, output ready);
endinterface

interface qslerp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic               used_linear;

    modport source (output valid, out_x, out_y, out_z, out_w, used_linear, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, used_linear, output ready);
endinterface
`default_nettype wire

[sv/quaternion_slerp_top.sv]
// Top level: quaternion spherical linear interpolation, front end, queue and back end.
//
//  channel    dir  handshake       payload
//  i_in_ch    in   valid/ready     first_*, second_*, fraction
//  o_out_ch   out  valid/ready     out_x/y/z/w, used_linear
//  i_cfg_*    in   write enable    lerp_epsilon
//
// One item per cycle while output is ready; path is front registers, queue, 69 back stages.
// The back depth is set by the 15-step square root, two 16-step CORDICs and 15-step divider.
// Reset clears valid bits, queue pointers and sets lerp_epsilon to 8.
// Output stalls freeze the back pipeline; the queue absorbs front items meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_slerp_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    qslerp_in_if.sink    i_in_ch,
    qslerp_out_if.source o_out_ch,
    input  wire          i_cfg_we,
    input  wire [14:0]   i_cfg_wdata
);
    import qslerp_pkg::*;

    t_cls q_in_item, q_out_item;
    logic q_push, q_full, q_valid, q_pop;

    qslerp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (i_in_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_item      (q_in_item)
    );

    qslerp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    qslerp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_out_item),
        .o_pop    (q_pop),
        .o_out_ch (o_out_ch)
    );
endmodule
`default_nettype wire

[sv/qslerp_front.sv]
// Front end: dot product, sign fold, fraction clamp and linear/spherical classification.
`timescale 1ns / 1ps
`default_nettype none
module qslerp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    qslerp_in_if.sink            i_in_ch,
    input  wire                  i_cfg_we,
    input  wire [14:0]           i_cfg_wdata,
    input  wire                  i_full,
    output logic                 o_push,
    output qslerp_pkg::t_cls     o_item
);
    import qslerp_pkg::*;

    logic [14:0]        r_eps;
    logic               r_v1, r_v2;
    logic [3:0][31:0]   r_prod;
    logic [3:0][15:0]   r_a1, r_b1;
    logic [14:0]        r_t1;
    t_cls               r_item;
    t_cls               n_item;
    logic               adv;
    logic [15:0]        in_a [4];
    logic [15:0]        in_b [4];
    logic [14:0]        t_sat;
    logic signed [33:0] p_sum;
    logic [33:0]        p_abs;
    logic [19:0]        dot_w;
    logic               neg;

    assign adv            = !r_v2 || !i_full;
    assign i_in_ch.ready  = adv;
    assign o_push         = r_v2 && !i_full;
    assign o_item         = r_item;

    always_comb begin
        in_a[0] = i_in_ch.first_x;
        in_a[1] = i_in_ch.first_y;
        in_a[2] = i_in_ch.first_z;
        in_a[3] = i_in_ch.first_w;
        in_b[0] = i_in_ch.second_x;
        in_b[1] = i_in_ch.second_y;
        in_b[2] = i_in_ch.second_z;
        in_b[3] = i_in_ch.second_w;
        t_sat   = (i_in_ch.fraction > 15'(ONE)) ? 15'(ONE) : i_in_ch.fraction;
    end

    always_comb begin
        p_sum = '0;
        for (int k = 0; k < 4; k++) begin
            p_sum = p_sum + 34'($signed(r_prod[k]));
        end
        neg   = p_sum[33];
        p_abs = neg ? 34'(-p_sum) : 34'(p_sum);
        dot_w = p_abs[33:FRAC_BITS];
        n_item = '0;
        for (int k = 0; k < 4; k++) begin
            n_item.a[k] = neg ? 17'(-$signed({r_a1[k][15], r_a1[k]}))
                              : {r_a1[k][15], r_a1[k]};
            n_item.b[k] = r_b1[k];
        end
        n_item.t   = r_t1;
        n_item.dot = (dot_w > 20'(ONE)) ? 15'(ONE) : dot_w[14:0];
        n_item.lin = ({1'b0, n_item.dot} + {1'b0, r_eps}) >= 16'(ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 15'(EPS_RESET);
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            if (adv) begin
                r_v1 <= i_in_ch.valid;
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= 32'($signed(in_a[k]) * $signed(in_b[k]));
                r_a1[k]   <= in_a[k];
                r_b1[k]   <= in_b[k];
            end
            r_t1   <= t_sat;
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

[sv/qslerp_queue.sv]
// Queue: four-entry buffer of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module qslerp_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  qslerp_pkg::t_cls     i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output qslerp_pkg::t_cls     o_item
);
    import qslerp_pkg::*;

    t_cls        r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        do_pop;

    assign o_full  = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

[sv/qslerp_back.sv]
// Back end: square root, CORDIC arctangent and sines, dividers and weighted blend.
`timescale 1ns / 1ps
`default_nettype none
module qslerp_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  qslerp_pkg::t_cls     i_item,
    output logic                 o_pop,
    qslerp_out_if.source         o_out_ch
);
    import qslerp_pkg::*;

    localparam int S_SQN  = 0;
    localparam int S_SQ0  = S_SQN + 1;
    localparam int S_CIN  = S_SQ0 + SQ_STEPS;
    localparam int S_AT0  = S_CIN + 1;
    localparam int S_ANG  = S_AT0 + CORDIC_STEPS;
    localparam int S_SN0  = S_ANG + 1;
    localparam int S_RND  = S_SN0 + CORDIC_STEPS;
    localparam int S_DV0  = S_RND + 1;
    localparam int S_SEL  = S_DV0 + DIV_STEPS;
    localparam int S_MUL  = S_SEL + 1;
    localparam int S_OUT  = S_MUL + 1;
    localparam int DEPTH  = S_OUT + 1;
    localparam int SH     = ANG_BITS - FRAC_BITS;

    typedef struct packed {
        t_cls               c;
        logic [28:0]        sq_n;
        logic [28:0]        sq_r;
        logic [14:0]        s;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [32:0] cz;
        logic [1:0][33:0]   sx;
        logic [1:0][33:0]   sy;
        logic [1:0][32:0]   sz;
        logic [1:0][30:0]   rem;
        logic [1:0][14:0]   q;
        logic [1:0]         sat;
        logic [14:0]        w0;
        logic [14:0]        w1;
        logic [3:0][34:0]   pa;
        logic [3:0][34:0]   pb;
        logic [3:0][15:0]   o;
    } t_work;

    function automatic t_work step(input int k, input t_work w);
        t_work              n;
        logic [29:0]        sq;
        logic [28:0]        bitv;
        logic signed [33:0] xs, ys, xv, yv;
        logic signed [32:0] zv;
        logic signed [48:0] prod;
        logic signed [17:0] rr;
        logic [15:0]        sine;
        logic [30:0]        dv;
        logic [14:0]        omt;
        logic signed [34:0] v;
        int                 j;
        n   = w;
        omt = 15'(ONE) - w.c.t;
        if (k == S_SQN) begin
            sq     = 30'(w.c.dot * w.c.dot);
            n.sq_n = 29'(30'(ONE * ONE) - sq);
            n.sq_r = '0;
        end else if (k < S_CIN) begin
            j    = k - S_SQ0;
            bitv = 29'(1) << (2 * (SQ_STEPS - 1 - j));
            if (w.sq_n >= w.sq_r + bitv) begin
                n.sq_n = w.sq_n - (w.sq_r + bitv);
                n.sq_r = (w.sq_r >> 1) + bitv;
            end else begin
                n.sq_r = w.sq_r >> 1;
            end
        end else if (k == S_CIN) begin
            n.s  = w.sq_r[14:0];
            n.cx = $signed({19'b0, w.c.dot}) <<< SH;
            n.cy = $signed({19'b0, w.sq_r[14:0]}) <<< SH;
            n.cz = '0;
        end else if (k < S_ANG) begin
            j  = k - S_AT0;
            xs = w.cx >>> j;
            ys = w.cy >>> j;
            if (w.cy > 0) begin
                n.cx = w.cx + ys;
                n.cy = w.cy - xs;
                n.cz = w.cz + atan_q30(j);
            end else begin
                n.cx = w.cx - ys;
                n.cy = w.cy + xs;
                n.cz = w.cz - atan_q30(j);
            end
        end else if (k == S_ANG) begin
            prod     = $signed({1'b0, omt}) * w.cz;
            n.sz[0]  = 33'(prod >>> FRAC_BITS);
            prod     = $signed({1'b0, w.c.t}) * w.cz;
            n.sz[1]  = 33'(prod >>> FRAC_BITS);
            for (int l = 0; l < 2; l++) begin
                n.sx[l] = 34'(CORDIC_GAIN);
                n.sy[l] = '0;
            end
        end else if (k < S_RND) begin
            j = k - S_SN0;
            for (int l = 0; l < 2; l++) begin
                xv = $signed(w.sx[l]);
                yv = $signed(w.sy[l]);
                zv = $signed(w.sz[l]);
                xs = xv >>> j;
                ys = yv >>> j;
                if (zv >= 0) begin
                    n.sx[l] = xv - ys;
                    n.sy[l] = yv + xs;
                    n.sz[l] = zv - atan_q30(j);
                end else begin
                    n.sx[l] = xv + ys;
                    n.sy[l] = yv - xs;
                    n.sz[l] = zv + atan_q30(j);
                end
            end
        end else if (k == S_RND) begin
            for (int l = 0; l < 2; l++) begin
                yv       = $signed(w.sy[l]) + 34'sd32768;
                rr       = 18'(yv >>> SH);
                sine     = rr[17] ? 16'd0 : rr[15:0];
                n.rem[l] = 31'(sine) << FRAC_BITS;
                n.q[l]   = '0;
                n.sat[l] = (w.s == 15'd0) || ({1'b0, sine} >= {1'b0, w.s, 1'b0});
            end
        end else if (k < S_SEL) begin
            j = DIV_STEPS - 1 - (k - S_DV0);
            for (int l = 0; l < 2; l++) begin
                dv = 31'(w.s) << j;
                if (w.rem[l] >= dv) begin
                    n.rem[l]  = w.rem[l] - dv;
                    n.q[l][j] = 1'b1;
                end
            end
        end else if (k == S_SEL) begin
            if (w.c.lin) begin
                n.w0 = omt;
                n.w1 = w.c.t;
            end else begin
                n.w0 = w.sat[0] ? 15'h7FFF : w.q[0];
                n.w1 = w.sat[1] ? 15'h7FFF : w.q[1];
            end
        end else if (k == S_MUL) begin
            for (int l = 0; l < 4; l++) begin
                n.pa[l] = 35'($signed({1'b0, w.w0}) * $signed(w.c.a[l]));
                n.pb[l] = 35'($signed({1'b0, w.w1}) * $signed(w.c.b[l]));
            end
        end else begin
            for (int l = 0; l < 4; l++) begin
                v = $signed(w.pa[l]) + $signed(w.pb[l]) + 35'(ONE / 2);
                v = v >>> FRAC_BITS;
                if (v > 35'sd32767) begin
                    n.o[l] = 16'h7FFF;
                end else if (v < -35'sd32768) begin
                    n.o[l] = 16'h8000;
                end else begin
                    n.o[l] = v[15:0];
                end
            end
        end
        return n;
    endfunction

    t_work              r_pipe [DEPTH];
    t_work              n_pipe [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_work              head;
    logic               adv;

    assign adv   = !r_vld[DEPTH-1] || o_out_ch.ready;
    assign o_pop = adv;

    always_comb begin
        head   = '0;
        head.c = i_item;
        n_pipe[0] = step(0, head);
        for (int k = 1; k < DEPTH; k++) begin
            n_pipe[k] = step(k, r_pipe[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_out_ch.valid       = r_vld[DEPTH-1];
    assign o_out_ch.out_x       = r_pipe[DEPTH-1].o[0];
    assign o_out_ch.out_y       = r_pipe[DEPTH-1].o[1];
    assign o_out_ch.out_z       = r_pipe[DEPTH-1].o[2];
    assign o_out_ch.out_w       = r_pipe[DEPTH-1].o[3];
    assign o_out_ch.used_linear = r_pipe[DEPTH-1].c.lin;
endmodule
`default_nettype wire

[dv/tb_quaternion_slerp_top.sv]
// Testbench: directed and random slerp items checked against an internal fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_slerp_top;
    import qslerp_pkg::*;

    typedef struct {
        logic signed [15:0] x, y, z, w;
        logic               lin;
    } t_quat_res;

    class slerp_board;
        t_quat_res pending[$];
        int        errors;
        int        eps;

        function new();
            errors = 0;
            eps    = EPS_RESET;
        endfunction

        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function longint isqrt(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 << 62;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint angle_of(longint y, longint x);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(atan_q30(i));
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(atan_q30(i));
                end
            end
            return z;
        endfunction

        function longint sine_of(longint a);
            longint x;
            longint y;
            longint xs;
            longint ys;
            longint r;
            x = CORDIC_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (a >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    a = a - longint'(atan_q30(i));
                end else begin
                    x = x + ys;
                    y = y - xs;
                    a = a + longint'(atan_q30(i));
                end
            end
            r = fshift(y + (64'sd1 << (ANG_BITS - FRAC_BITS - 1)), ANG_BITS - FRAC_BITS);
            return (r < 0) ? 0 : r;
        endfunction

        function longint weight(longint num, longint den);
            longint qmax;
            longint q;
            qmax = 2 * ONE - 1;
            if (den <= 0 || num >= 2 * den) return qmax;
            q = (num << FRAC_BITS) / den;
            return (q > qmax) ? qmax : q;
        endfunction

        function void note_input(logic signed [15:0] a_in[4], logic signed [15:0] b_in[4],
                                 logic [14:0] frac);
            longint a[4];
            longint b[4];
            longint p, t, dot, w0, w1, s, th, v;
            longint o[4];
            t_quat_res r;
            p = 0;
            for (int k = 0; k < 4; k++) begin
                a[k] = a_in[k];
                b[k] = b_in[k];
                p = p + a[k] * b[k];
            end
            t = frac;
            if (t > ONE) t = ONE;
            if (p < 0) begin
                for (int k = 0; k < 4; k++) a[k] = -a[k];
                p = -p;
            end
            dot = p >>> FRAC_BITS;
            if (dot > ONE) dot = ONE;
            r.lin = (dot >= ONE - eps);
            if (r.lin) begin
                w0 = ONE - t;
                w1 = t;
            end else begin
                s  = isqrt(longint'(ONE) * ONE - dot * dot);
                th = angle_of(s << (ANG_BITS - FRAC_BITS), dot << (ANG_BITS - FRAC_BITS));
                w0 = weight(sine_of(fshift((ONE - t) * th, FRAC_BITS)), s);
                w1 = weight(sine_of(fshift(t * th, FRAC_BITS)), s);
            end
            for (int k = 0; k < 4; k++) begin
                v = fshift(w0 * a[k] + w1 * b[k] + (ONE >> 1), FRAC_BITS);
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                o[k] = v;
            end
            r.x = 16'(o[0]);
            r.y = 16'(o[1]);
            r.z = 16'(o[2]);
            r.w = 16'(o[3]);
            pending.push_back(r);
        endfunction

        function void check_result(t_quat_res got);
            t_quat_res e;
            if (pending.size() == 0) begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) begin
                $error("out_x exp %0d got %0d", e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $error("out_y exp %0d got %0d", e.y, got.y); errors++;
            end
            if (got.z !== e.z) begin
                $error("out_z exp %0d got %0d", e.z, got.z); errors++;
            end
            if (got.w !== e.w) begin
                $error("out_w exp %0d got %0d", e.w, got.w); errors++;
            end
            if (got.lin !== e.lin) begin
                $error("used_linear exp %0b got %0b", e.lin, got.lin); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    bit          calm;
    int          hold_off;
    slerp_board  board;

    qslerp_in_if  in_ch ();
    qslerp_out_if out_ch ();

    quaternion_slerp_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_quaternion_slerp_top: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        t_quat_res r;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_input('{in_ch.first_x, in_ch.first_y, in_ch.first_z, in_ch.first_w},
                             '{in_ch.second_x, in_ch.second_y, in_ch.second_z,
                               in_ch.second_w}, in_ch.fraction);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.x   = out_ch.out_x;
            r.y   = out_ch.out_y;
            r.z   = out_ch.out_z;
            r.w   = out_ch.out_w;
            r.lin = out_ch.used_linear;
            board.check_result(r);
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    task automatic send_item(logic signed [15:0] a[4], logic signed [15:0] b[4],
                             logic [14:0] frac);
        while (!calm && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.first_x  <= a[0];
        in_ch.first_y  <= a[1];
        in_ch.first_z  <= a[2];
        in_ch.first_w  <= a[3];
        in_ch.second_x <= b[0];
        in_ch.second_y <= b[1];
        in_ch.second_z <= b[2];
        in_ch.second_w <= b[3];
        in_ch.fraction <= frac;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_epsilon(logic [14:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        board.eps = v;
    endtask

    function automatic logic signed [15:0] rand_comp(bit unit_scale);
        if (unit_scale) return $signed(16'($urandom_range(16384))) - 16'sd8192;
        return 16'($urandom);
    endfunction

    task automatic random_items(int n);
        logic signed [15:0] a[4];
        logic signed [15:0] b[4];
        logic [14:0]        frac;
        int                 kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            for (int k = 0; k < 4; k++) begin
                a[k] = rand_comp(kind < 7);
                b[k] = (kind == 5) ? a[k] + $signed(16'($urandom_range(8))) - 16'sd4
                     : (kind == 6) ? -a[k] : rand_comp(kind < 7);
            end
            frac = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
            send_item(a, b, frac);
        end
    endtask

    initial begin
        logic signed [15:0] q0[4];
        logic signed [15:0] q1[4];
        logic [14:0]        fr[5];
        board          = new();
        calm           = 1'b0;
        hold_off       = 0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.first_x  = '0;
        in_ch.first_y  = '0;
        in_ch.first_z  = '0;
        in_ch.first_w  = '0;
        in_ch.second_x = '0;
        in_ch.second_y = '0;
        in_ch.second_z = '0;
        in_ch.second_w = '0;
        in_ch.fraction = '0;
        out_ch.ready   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        fr = '{15'd0, 15'd16384, 15'd8192, 15'd32767, 15'd1};
        foreach (fr[j]) begin
            send_item('{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                      fr[j]);
            send_item('{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, '{16'sd0, 16'sd0, 16'sd0, -16'sd16384},
                      fr[j]);
        end
        send_item('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
                  '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 15'd8192);
        send_item('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
                  '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 15'd4096);
        send_item('{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 15'd100);
        send_item('{16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
                  '{16'sd0, 16'sd11585, 16'sd0, 16'sd11585}, 15'd5000);
        send_item('{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                  '{16'sd16380, 16'sd360, 16'sd0, 16'sd0}, 15'd8192);
        send_item('{-16'sd32768, 16'sd32767, -16'sd1, 16'sd1},
                  '{16'sd1, -16'sd2, 16'sd32767, -16'sd32768}, 15'd12000);

        random_items(450);
        write_epsilon(15'd0);
        calm = 1'b1;
        random_items(300);
        calm = 1'b0;
        hold_off = 400;
        random_items(200);
        write_epsilon(15'd16384);
        random_items(200);
        write_epsilon(15'd32767);
        random_items(100);
        write_epsilon(15'd300);
        random_items(300);
        drain();
        random_items(200);

        drain();
        if (board.errors == 0) begin
            $display("tb_quaternion_slerp_top: PASS");
        end else begin
            $display("tb_quaternion_slerp_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
